// ===== rtl/battery_level_gauge_core_macros.svh =====
// Assertion macros shared by the battery level gauge RTL.
`ifndef BATTERY_LEVEL_GAUGE_CORE_MACROS_SVH
`define BATTERY_LEVEL_GAUGE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BLG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("battery gauge check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BLG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("battery gauge check failed");

`endif

// ===== rtl/blg_pkg.sv =====
// Shared constants, types and sequencer states of the battery level gauge.
package blg_pkg;

  // Converter resolution used by the filter and the port widths.
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned MV_W        = 14;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned CFG_ADDR_W  = 2;

  // Voltage is the filtered value times four, never narrower than a register.
  localparam int unsigned VOLT_W = (SAMPLE_BITS + 2 > MV_W) ? SAMPLE_BITS + 2 : MV_W;
  // Percent map numerator (v - min) * 100 and the pre-shifted divisor.
  localparam int unsigned NUM_W  = VOLT_W + PCT_W;
  localparam int unsigned DSR_W  = MV_W + PCT_W - 1;

  // Divide by five through a reciprocal: exact for every sum below 2^(SUM_W).
  localparam int unsigned SUM_W      = SAMPLE_BITS + 3;
  localparam int unsigned EMA_SHIFT  = SAMPLE_BITS + 5;
  localparam int unsigned PROD_W     = 2 * SUM_W;
  localparam logic [SUM_W-1:0] EMA_RECIP = SUM_W'(((2 ** EMA_SHIFT) + 4) / 5);

  localparam logic [PCT_W-1:0] PCT_EMPTY = PCT_W'(0);
  localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_MV    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_MV    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHARGE_MV = 2'd2;

  localparam logic [MV_W-1:0] RST_MIN_MV    = MV_W'(3000);
  localparam logic [MV_W-1:0] RST_MAX_MV    = MV_W'(4200);
  localparam logic [MV_W-1:0] RST_CHARGE_MV = MV_W'(4300);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_MAP,
    ST_DIV,
    ST_OUT
  } state_e;

  // Request to the divider.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [MV_W-1:0]  den;
  } div_req_t;

  // Response of the divider.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PCT_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/blg_div.sv =====
// Bit-serial restoring divider for the percent map, one quotient bit per cycle.
module blg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  blg_pkg::div_req_t req_i,
  output blg_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NUM_W = blg_pkg::NUM_W;
  localparam int unsigned DSR_W = blg_pkg::DSR_W;
  localparam int unsigned PCT_W = blg_pkg::PCT_W;
  localparam int unsigned CNT_W = $clog2(PCT_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [PCT_W-1:0] quo_q, quo_d;
  logic [NUM_W-1:0] dsr_ext;
  logic             fits;

  // One compare and subtract against the current divisor alignment.
  assign dsr_ext = NUM_W'(dsr_q);
  assign fits    = (rem_q >= dsr_ext);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(PCT_W - 1);
      rem_d  = req_i.num;
      dsr_d  = {req_i.den, {(PCT_W-1){1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsr_ext;
      end
      quo_d = {quo_q[PCT_W-2:0], fits};
      dsr_d = dsr_q >> 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state resets; the datapath needs none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/battery_level_gauge_core.sv =====
// Top level of the battery level gauge: filter, percent sequencer and ports.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------
//  in      | input     | in_valid_i / in_ready_o  | sample_mv_i
//  out     | output    | out_valid_o / out_ready_i| battery_mv_o, level_pct_o, charging_o
//  cfg     | input     | cfg_we_i (no wait)       | cfg_addr_i, cfg_wdata_i
//
// When the level is clipped at 0 or 100, a word passes from acceptance to
// result through a filter step, a range check and an output load. When the
// percent map divides, the range check starts the divider, which builds the
// 7-bit quotient one bit per cycle, and the quotient goes into the level
// register before the output load. in_ready_o is high only while the
// sequencer is idle. A finished result waits in the output register; the
// next word is accepted while it waits, and that word's result is held back
// until the output register is free.
// Reset clears the filter, the charging flag and loads the default registers.
`include "battery_level_gauge_core_macros.svh"

module battery_level_gauge_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [blg_pkg::SAMPLE_W-1:0]     sample_mv_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [blg_pkg::MV_W-1:0]         battery_mv_o,
  output logic [blg_pkg::PCT_W-1:0]        level_pct_o,
  output logic                             charging_o,
  input  logic                             cfg_we_i,
  input  logic [blg_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [blg_pkg::MV_W-1:0]         cfg_wdata_i
);

  localparam int unsigned SB     = blg_pkg::SAMPLE_BITS;
  localparam int unsigned MV_W   = blg_pkg::MV_W;
  localparam int unsigned PCT_W  = blg_pkg::PCT_W;
  localparam int unsigned VOLT_W = blg_pkg::VOLT_W;
  localparam int unsigned NUM_W  = blg_pkg::NUM_W;
  localparam int unsigned SUM_W  = blg_pkg::SUM_W;
  localparam int unsigned PROD_W = blg_pkg::PROD_W;

  blg_pkg::state_e   state_q, state_d;
  blg_pkg::div_req_t div_req;
  blg_pkg::div_rsp_t div_rsp;

  logic [MV_W-1:0]   min_q, max_q, thr_q;
  logic [SB-1:0]     sample_q;
  logic [SB-1:0]     filt_q, filt_d;
  logic              primed_q;
  logic              flag_q, flag_d;
  logic [PCT_W-1:0]  pct_q, pct_d;
  logic              out_valid_q;
  logic [MV_W-1:0]   out_mv_q;
  logic [PCT_W-1:0]  out_pct_q;
  logic              out_chg_q;

  // Sequencer controls.
  logic in_take, filt_load, map_run, div_take, out_load;

  // Exponential average: floor((sample + 4*old)/5) by reciprocal; first sample as is.
  logic [SUM_W-1:0]  ema_sum;
  logic [PROD_W-1:0] ema_prod;
  assign ema_sum  = SUM_W'(sample_q) + SUM_W'({filt_q, 2'b00});
  assign ema_prod = PROD_W'(ema_sum) * PROD_W'(blg_pkg::EMA_RECIP);
  assign filt_d   = primed_q ? ema_prod[blg_pkg::EMA_SHIFT +: SB] : sample_q;

  // Battery voltage and the range checks of the percent map.
  logic [VOLT_W-1:0] volts;
  logic [VOLT_W-1:0] min_ext, max_ext, thr_ext;
  logic              at_empty, at_full;
  assign volts    = {filt_q, 2'b00};
  assign min_ext  = VOLT_W'(min_q);
  assign max_ext  = VOLT_W'(max_q);
  assign thr_ext  = VOLT_W'(thr_q);
  assign at_empty = (volts <= min_ext);
  assign at_full  = (volts >= max_ext);

  // Divider operands, used only when min < v < max.
  assign div_req.start = map_run && !at_empty && !at_full;
  assign div_req.num   = NUM_W'(volts - min_ext) * NUM_W'(blg_pkg::PCT_FULL);
  assign div_req.den   = max_q - min_q;

  blg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      blg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = blg_pkg::ST_FILT;
        end
      end
      blg_pkg::ST_FILT: state_d = blg_pkg::ST_MAP;
      blg_pkg::ST_MAP: begin
        if (at_empty || at_full) begin
          state_d = blg_pkg::ST_OUT;
        end else begin
          state_d = blg_pkg::ST_DIV;
        end
      end
      blg_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = blg_pkg::ST_OUT;
        end
      end
      blg_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = blg_pkg::ST_IDLE;
        end
      end
      default: state_d = blg_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    filt_load  = 1'b0;
    map_run    = 1'b0;
    div_take   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      blg_pkg::ST_IDLE: in_ready_o = 1'b1;
      blg_pkg::ST_FILT: filt_load  = 1'b1;
      blg_pkg::ST_MAP:  map_run    = 1'b1;
      blg_pkg::ST_DIV:  div_take   = div_rsp.done;
      blg_pkg::ST_OUT:  out_load   = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign in_take = in_valid_i && in_ready_o;

  // Level and charging flag after the range checks or the division.
  always_comb begin
    pct_d  = pct_q;
    flag_d = flag_q;
    if (map_run) begin
      if (at_empty) begin
        pct_d = blg_pkg::PCT_EMPTY;
      end else if (at_full) begin
        pct_d  = blg_pkg::PCT_FULL;
        flag_d = (volts > thr_ext);
      end
    end else if (div_take) begin
      pct_d = div_rsp.quo;
    end
  end

  // Control state, filter state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blg_pkg::ST_IDLE;
      primed_q    <= 1'b0;
      filt_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      min_q       <= blg_pkg::RST_MIN_MV;
      max_q       <= blg_pkg::RST_MAX_MV;
      thr_q       <= blg_pkg::RST_CHARGE_MV;
    end else begin
      state_q <= state_d;
      flag_q  <= flag_d;
      if (filt_load) begin
        filt_q   <= filt_d;
        primed_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          blg_pkg::CFG_MIN_MV:    min_q <= cfg_wdata_i;
          blg_pkg::CFG_MAX_MV:    max_q <= cfg_wdata_i;
          blg_pkg::CFG_CHARGE_MV: thr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pct_q <= pct_d;
    if (in_take) begin
      sample_q <= SB'(sample_mv_i);
    end
    if (out_load) begin
      out_mv_q  <= volts[MV_W-1:0];
      out_pct_q <= pct_q;
      out_chg_q <= flag_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign battery_mv_o = out_mv_q;
  assign level_pct_o  = out_pct_q;
  assign charging_o   = out_chg_q;

  // The divider only runs while no new word can enter.
  `BLG_ASSERT_IMP(a_div_blocks_input, div_rsp.busy, !in_ready_o)
  // An accepted word closes the input until its result is made.
  `BLG_ASSERT_NXT(a_take_closes_input, in_take, !in_ready_o)
  // A result never reports more than a full battery.
  `BLG_ASSERT_IMP(a_pct_in_range, out_valid_o, level_pct_o <= blg_pkg::PCT_FULL)
  // The charging flag only changes together with a full reading.
  `BLG_ASSERT_IMP(a_charge_at_full, out_valid_o && $rose(charging_o),
                  level_pct_o == blg_pkg::PCT_FULL)

endmodule
